// ----- design/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants for the sorted priority queue
// Queue depth, index and count widths, action and status codes, slot and
// result records exchanged between the walker and the top level.
// ----------------------------------------------------------------------------
package spq_pkg;

	// Queue geometry
	localparam int DEPTH  = 16;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int DATA_W = 16;
	localparam int ACT_W  = 3;
	localparam int ST_W   = 2;

	// Action codes
	localparam logic [ACT_W-1:0] ACT_INSERT = 3'd0;
	localparam logic [ACT_W-1:0] ACT_TAKE   = 3'd1;
	localparam logic [ACT_W-1:0] ACT_PEEK   = 3'd2;
	localparam logic [ACT_W-1:0] ACT_REMOVE = 3'd3;
	localparam logic [ACT_W-1:0] ACT_FIND   = 3'd4;

	// Status codes
	localparam logic [ST_W-1:0] ST_OK       = 2'd0;
	localparam logic [ST_W-1:0] ST_EMPTY    = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL     = 2'd2;
	localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd3;

	// One stored entry
	typedef struct packed {
		logic [DATA_W-1:0] handle;
		logic [DATA_W-1:0] prio;
	} slot_t;

	// Finished operation from the walker
	typedef struct packed {
		logic              done;
		logic [DATA_W-1:0] handle;
		logic [DATA_W-1:0] prio;
		logic [ST_W-1:0]   status;
		logic [CNT_W-1:0]  count;
	} result_t;

endpackage

// ----- design/spq_slot_ram.sv -----
// ----------------------------------------------------------------------------
// spq_slot_ram: entry storage
// One write port and one read port, read data registered. No reset: only
// entries below the held count are ever read.
// ----------------------------------------------------------------------------
module spq_slot_ram (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [spq_pkg::IDX_W-1:0]  wr_addr,
	input  spq_pkg::slot_t             wr_data,
	input  logic                       rd_en,
	input  logic [spq_pkg::IDX_W-1:0]  rd_addr,
	output spq_pkg::slot_t             rd_data
);
	import spq_pkg::*;

	slot_t mem [DEPTH];
	slot_t rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- design/spq_walker.sv -----
// ----------------------------------------------------------------------------
// spq_walker: operation sequencer
// Walks the slot RAM one entry per cycle with a single compare unit.
// Insert walks down from the tail shifting entries up until the new entry
// fits; take and remove walk up from the head shifting entries down after
// the match; peek and find stop at the first match.
// ----------------------------------------------------------------------------
module spq_walker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [spq_pkg::ACT_W-1:0]   action,
	input  logic [spq_pkg::DATA_W-1:0]  item_handle,
	input  logic [spq_pkg::DATA_W-1:0]  item_priority,
	input  logic                        res_take,
	output logic                        busy,
	output spq_pkg::result_t            res
);
	import spq_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_PLACE,
		S_FINISH
	} state_t;

	state_t              state_q;
	logic [ACT_W-1:0]    op_q;
	logic [DATA_W-1:0]   hdl_q;
	logic [DATA_W-1:0]   pri_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [IDX_W-1:0]    rd_idx_q;
	logic                rd_more_q;
	logic                rd_vld_s1;
	logic [IDX_W-1:0]    rd_pos_s1;
	logic                found_q;
	logic [DATA_W-1:0]   res_hdl_q;
	logic [DATA_W-1:0]   res_pri_q;
	logic [ST_W-1:0]     res_st_q;

	logic                wr_en;
	logic [IDX_W-1:0]    wr_addr;
	slot_t               wr_data;
	logic                rd_en;
	slot_t               rd_data;
	slot_t               new_slot;
	logic                is_ins;
	logic                is_head_op;
	logic                last;
	logic                ge;
	logic                match;
	logic [CNT_W-1:0]    next_idx_ext;

	spq_slot_ram u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_idx_q),
		.rd_data (rd_data)
	);

	// shared compare unit and decode
	assign new_slot     = '{handle: hdl_q, prio: pri_q};
	assign is_ins       = (op_q == ACT_INSERT);
	assign is_head_op   = (op_q == ACT_TAKE) || (op_q == ACT_PEEK);
	assign last         = ({1'b0, rd_pos_s1} == (cnt_q - 1'b1));
	assign ge           = (rd_data.prio >= pri_q);
	assign match        = is_head_op || (rd_data.handle == hdl_q);
	assign next_idx_ext = {1'b0, rd_idx_q} + 1'b1;
	assign rd_en        = (state_q == S_SCAN) && rd_more_q;

	// RAM write: shift on the walk, or place the new entry
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = new_slot;
		if (state_q == S_PLACE) begin
			wr_en = 1'b1;
		end else if (state_q == S_SCAN && rd_vld_s1) begin
			if (is_ins) begin
				wr_en   = 1'b1;
				wr_addr = rd_pos_s1 + 1'b1;
				wr_data = ge ? rd_data : new_slot;
			end else if (found_q) begin
				wr_en   = 1'b1;
				wr_addr = rd_pos_s1 - 1'b1;
				wr_data = rd_data;
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			op_q      <= ACT_INSERT;
			hdl_q     <= '0;
			pri_q     <= '0;
			cnt_q     <= '0;
			rd_idx_q  <= '0;
			rd_more_q <= 1'b0;
			rd_vld_s1 <= 1'b0;
			rd_pos_s1 <= '0;
			found_q   <= 1'b0;
			res_hdl_q <= '0;
			res_pri_q <= '0;
			res_st_q  <= ST_OK;
		end else begin
			case (state_q)
				S_IDLE: begin
					rd_vld_s1 <= 1'b0;
					rd_more_q <= 1'b0;
					if (start) begin
						op_q      <= action;
						hdl_q     <= item_handle;
						pri_q     <= item_priority;
						found_q   <= 1'b0;
						res_hdl_q <= '0;
						res_pri_q <= '0;
						res_st_q  <= ST_OK;
						rd_idx_q  <= '0;
						case (action)
							ACT_INSERT: begin
								if (cnt_q == CNT_W'(DEPTH)) begin
									res_st_q <= ST_FULL;
									state_q  <= S_FINISH;
								end else if (cnt_q == '0) begin
									state_q <= S_PLACE;
								end else begin
									rd_idx_q  <= IDX_W'(cnt_q - 1'b1);
									rd_more_q <= 1'b1;
									state_q   <= S_SCAN;
								end
							end
							ACT_TAKE, ACT_PEEK, ACT_REMOVE: begin
								if (cnt_q == '0) begin
									res_st_q <= ST_EMPTY;
									state_q  <= S_FINISH;
								end else begin
									rd_more_q <= 1'b1;
									state_q   <= S_SCAN;
								end
							end
							ACT_FIND: begin
								if (cnt_q == '0) begin
									res_st_q <= ST_NOTFOUND;
									state_q  <= S_FINISH;
								end else begin
									rd_more_q <= 1'b1;
									state_q   <= S_SCAN;
								end
							end
							default: begin
								state_q <= S_FINISH;
							end
						endcase
					end
				end
				S_SCAN: begin
					// read issue
					rd_vld_s1 <= rd_en;
					rd_pos_s1 <= rd_idx_q;
					if (rd_en) begin
						if (is_ins) begin
							rd_idx_q  <= rd_idx_q - 1'b1;
							rd_more_q <= (rd_idx_q != '0);
						end else begin
							rd_idx_q  <= IDX_W'(next_idx_ext);
							rd_more_q <= (next_idx_ext < cnt_q);
						end
					end
					// data stage
					if (rd_vld_s1) begin
						if (is_ins) begin
							if (ge) begin
								if (rd_pos_s1 == '0) begin
									state_q   <= S_PLACE;
									rd_more_q <= 1'b0;
									rd_vld_s1 <= 1'b0;
								end
							end else begin
								cnt_q     <= cnt_q + 1'b1;
								state_q   <= S_FINISH;
								rd_more_q <= 1'b0;
								rd_vld_s1 <= 1'b0;
							end
						end else if (!found_q) begin
							if (match) begin
								found_q <= 1'b1;
								if (op_q != ACT_REMOVE) begin
									res_hdl_q <= rd_data.handle;
									res_pri_q <= rd_data.prio;
								end
								if (op_q == ACT_PEEK || op_q == ACT_FIND || last) begin
									if (op_q == ACT_TAKE || op_q == ACT_REMOVE) begin
										cnt_q <= cnt_q - 1'b1;
									end
									state_q   <= S_FINISH;
									rd_more_q <= 1'b0;
									rd_vld_s1 <= 1'b0;
								end
							end else if (last) begin
								res_st_q  <= ST_NOTFOUND;
								state_q   <= S_FINISH;
								rd_more_q <= 1'b0;
								rd_vld_s1 <= 1'b0;
							end
						end else if (last) begin
							cnt_q     <= cnt_q - 1'b1;
							state_q   <= S_FINISH;
							rd_more_q <= 1'b0;
							rd_vld_s1 <= 1'b0;
						end
					end
				end
				S_PLACE: begin
					cnt_q   <= cnt_q + 1'b1;
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy       = (state_q != S_IDLE);
	assign res.done   = (state_q == S_FINISH);
	assign res.handle = res_hdl_q;
	assign res.prio   = res_pri_q;
	assign res.status = res_st_q;
	assign res.count  = cnt_q;

endmodule

// ----- design/sorted_priority_queue_core.sv -----
// ----------------------------------------------------------------------------
// sorted_priority_queue_core: sorted minimum priority queue
// Holds up to DEPTH handle/priority entries in ascending priority order and
// applies one insert, take, peek, remove or find per input beat, returning
// one result beat with status and the count held afterwards.
//
//   channel | direction | handshake           | fields
//   in      | to core   | in_valid, in_stall  | action, item_handle, item_priority
//   out     | from core | out_valid, out_stall| out_handle, out_priority, status,
//           |           |                     | entry_count
//
// Peek, and find at the head, stop at the first entry; take and remove walk
// all held entries, find walks up to the match and insert walks down from
// the tail, one entry per cycle over the slot RAM. in_stall is high
// while an operation is in progress. A result waits in the output register
// under out_stall; the walker holds the next result until that register frees.
// Reset empties the queue at once; slot contents are not cleared.
// ----------------------------------------------------------------------------
module sorted_priority_queue_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [spq_pkg::ACT_W-1:0]   action,
	input  logic [spq_pkg::DATA_W-1:0]  item_handle,
	input  logic [spq_pkg::DATA_W-1:0]  item_priority,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [spq_pkg::DATA_W-1:0]  out_handle,
	output logic [spq_pkg::DATA_W-1:0]  out_priority,
	output logic [spq_pkg::ST_W-1:0]    status,
	output logic [spq_pkg::CNT_W-1:0]   entry_count
);
	import spq_pkg::*;

	logic              busy;
	logic              start;
	logic              res_take;
	result_t           res;
	logic              out_valid_q;
	logic [DATA_W-1:0] out_handle_q;
	logic [DATA_W-1:0] out_priority_q;
	logic [ST_W-1:0]   status_q;
	logic [CNT_W-1:0]  entry_count_q;

	assign in_stall = busy;
	assign start    = in_valid && !busy;
	assign res_take = res.done && (!out_valid_q || !out_stall);

	spq_walker u_walker (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.action        (action),
		.item_handle   (item_handle),
		.item_priority (item_priority),
		.res_take      (res_take),
		.busy          (busy),
		.res           (res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_handle_q   <= res.handle;
			out_priority_q <= res.prio;
			status_q       <= res.status;
			entry_count_q  <= res.count;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_handle   = out_handle_q;
	assign out_priority = out_priority_q;
	assign status       = status_q;
	assign entry_count  = entry_count_q;

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (entry_count <= CNT_W'(DEPTH)))
		else $error("entry count above depth");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_FULL) |-> (entry_count == CNT_W'(DEPTH)))
		else $error("full status with room left");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_EMPTY) |-> (entry_count == '0))
		else $error("empty status with entries held");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("core took a beat without going busy");

	a_zero_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_OK) |-> (out_handle == '0 && out_priority == '0))
		else $error("handle or priority not zero on error status");

endmodule
